>>> sv/linear_probe_hash_table_assert.svh
// Assertion macros for the hash table block
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
// implication checked on every edge out of reset
`define LPHT_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define LPHT_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

>>> sv/lpht_pkg.sv
// Package: codes and types for the hash table
`timescale 1ns / 1ps
package lpht_pkg;
  // slot count; a power of two so the home slot is the low hash bits
  localparam int CAPACITY = 64;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_OCC   = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED  = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;

  localparam logic [63:0] DJB2_SEED = 64'd5381;

  // hash unit control
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } hash_ctl_t;
endpackage

>>> sv/lpht_hash.sv
// DJB2 hash unit: one key byte per cycle, shared shift-add
`timescale 1ns / 1ps
module lpht_hash #(
  parameter int KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] key,
  input  logic [3:0]  len,
  output logic        busy,
  output logic        done,
  output logic [63:0] hash
);
  logic [63:0] h_r, h_nxt;
  logic [3:0]  i_r, i_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [7:0]  byte_w;

  assign byte_w = key[{i_r[2:0], 3'b000} +: 8];

  always_comb begin
    h_nxt = h_r;
    i_nxt = i_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      h_nxt = lpht_pkg::DJB2_SEED;
      i_nxt = 4'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (i_r >= len) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        h_nxt = (h_r << 5) + h_r + {56'd0, byte_w};
        i_nxt = i_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    h_r <= h_nxt;
    i_r <= i_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign hash = h_r;

  `include "linear_probe_hash_table_assert.svh"
  `LPHT_ASSERT_NXT(a_done_once, clk, rst_n, done_r, !done_r)
  `LPHT_ASSERT_IMP(a_len_ok, clk, rst_n, busy_r, i_r <= 4'(KEY_BYTES))
  `LPHT_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_r)
endmodule

>>> sv/linear_probe_hash_table.sv
// Top level: linear-probing hash table with a serial probe sequencer
// Flow: hash the key, then read and check each probed slot in turn (S_READ,
// S_CHECK), write back in S_WRITE when a slot is written, then raise out_tvalid
// in S_OUT. Throughput: one operation at a time; in_tready returns the cycle
// after the result beat. Reset: synchronous active low; clears counters, limit
// to 48, then sweeps the mark memory empty, one slot per cycle, not ready.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
  parameter int KEY_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [6:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // tdata: opcode[1:0], key_bytes[65:2], key_len[69:66], chord_value[101:70],
  // voicing_ref[133:102], zero fill to 136
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tdata: status[2:0], chord_out[34:3], voicing_out[66:35], slot_index[72:67],
  // live_entries[79:73], used_count[86:80], zero fill to 88
  output logic [87:0]  out_tdata
);
  localparam int CAPACITY = lpht_pkg::CAPACITY;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_HASH, S_READ, S_CHECK, S_WRITE, S_OUT
  } state_t;

  state_t state_r;
  logic [AW-1:0] clr_r, s_r, tomb_r, wslot_r;
  logic          have_tomb_r;
  logic [CW-1:0] n_r, entry_r, used_r;
  logic [6:0]    max_r;
  logic [1:0]    op_r;
  logic [63:0]   key_r;
  logic [3:0]    len_r;
  logic [31:0]   chord_r, voic_r;
  logic [2:0]    st_r;
  logic [31:0]   co_r, vo_r;
  logic [AW-1:0] idx_r;
  logic          wr_occ_r, wr_data_r, wr_tomb_r;
  logic          out_v_r;

  // slot memories
  logic [1:0]  mark_mem [CAPACITY];
  logic [67:0] key_mem  [CAPACITY];
  logic [63:0] pay_mem  [CAPACITY];
  logic [1:0]  mark_q;
  logic [67:0] key_q;
  logic [63:0] pay_q;

  // input decode
  logic [3:0]  len_in;
  logic [63:0] mask_in;
  always_comb begin
    len_in = (in_tdata[69:66] > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_tdata[69:66];
    mask_in = (len_in >= 4'd8) ? '1 : ((64'd1 << {len_in, 3'b000}) - 64'd1);
  end

  logic        h_start, h_busy, h_done;
  logic [63:0] h_val;
  assign h_start = (state_r == S_IDLE) && in_tvalid;
  lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
    .clk(clk), .rst_n(rst_n), .start(h_start),
    .key(key_r), .len(len_r), .busy(h_busy), .done(h_done), .hash(h_val)
  );

  // memory port; reads the slot under probe
  always_ff @(posedge clk) begin
    mark_q <= mark_mem[s_r];
    key_q  <= key_mem[s_r];
    pay_q  <= pay_mem[s_r];
    if (state_r == S_CLEAR) mark_mem[clr_r] <= lpht_pkg::MARK_EMPTY;
    else if (state_r == S_WRITE) begin
      if (wr_tomb_r) mark_mem[wslot_r] <= lpht_pkg::MARK_TOMB;
      if (wr_occ_r) begin
        mark_mem[wslot_r] <= lpht_pkg::MARK_OCC;
        key_mem[wslot_r]  <= {len_r, key_r};
      end
      if (wr_data_r) pay_mem[wslot_r] <= {voic_r, chord_r};
    end
  end

  logic          match, last;
  logic [AW-1:0] s_inc;
  always_comb begin
    match = (mark_q == lpht_pkg::MARK_OCC) && (key_q == {len_r, key_r});
    last  = (n_r == CW'(CAPACITY - 1));
    s_inc = (s_r == AW'(CAPACITY - 1)) ? '0 : s_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      entry_r <= '0;
      used_r <= '0;
      max_r <= 7'd48;
      out_v_r <= 1'b0;
      wr_occ_r <= 1'b0;
      wr_data_r <= 1'b0;
      wr_tomb_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CAPACITY - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_tvalid) begin
            op_r <= in_tdata[1:0];
            key_r <= in_tdata[65:2] & mask_in;
            len_r <= len_in;
            chord_r <= in_tdata[101:70];
            voic_r <= in_tdata[133:102];
            have_tomb_r <= 1'b0;
            n_r <= '0;
            st_r <= lpht_pkg::ST_NOTFOUND;
            co_r <= '0;
            vo_r <= '0;
            idx_r <= '0;
            wr_occ_r <= 1'b0;
            wr_data_r <= 1'b0;
            wr_tomb_r <= 1'b0;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (h_done) begin
            // home slot: hash modulo a power-of-two capacity
            s_r <= h_val[AW-1:0];
            if (op_r == lpht_pkg::OP_INSERT || op_r == lpht_pkg::OP_FIND ||
                op_r == lpht_pkg::OP_REMOVE) state_r <= S_READ;
            else state_r <= S_OUT;
          end
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          state_r <= S_READ;
          s_r <= s_inc;
          n_r <= n_r + CW'(1);
          if (op_r == lpht_pkg::OP_INSERT) begin
            if (mark_q == lpht_pkg::MARK_EMPTY) begin
              if (have_tomb_r) begin
                wslot_r <= tomb_r; idx_r <= tomb_r;
                st_r <= lpht_pkg::ST_INSERTED;
                wr_occ_r <= 1'b1; wr_data_r <= 1'b1;
                entry_r <= entry_r + CW'(1);
              end else if (used_r >= max_r) begin
                st_r <= lpht_pkg::ST_FULL;
              end else begin
                wslot_r <= s_r; idx_r <= s_r;
                st_r <= lpht_pkg::ST_INSERTED;
                wr_occ_r <= 1'b1; wr_data_r <= 1'b1;
                entry_r <= entry_r + CW'(1);
                used_r <= used_r + CW'(1);
              end
              state_r <= S_WRITE;
            end else if (match) begin
              wslot_r <= s_r; idx_r <= s_r;
              st_r <= lpht_pkg::ST_UPDATED;
              wr_data_r <= 1'b1;
              state_r <= S_WRITE;
            end else begin
              if (mark_q == lpht_pkg::MARK_TOMB && !have_tomb_r) begin
                have_tomb_r <= 1'b1; tomb_r <= s_r;
              end
              if (last) begin
                if (have_tomb_r || mark_q == lpht_pkg::MARK_TOMB) begin
                  wslot_r <= have_tomb_r ? tomb_r : s_r;
                  idx_r <= have_tomb_r ? tomb_r : s_r;
                  st_r <= lpht_pkg::ST_INSERTED;
                  wr_occ_r <= 1'b1; wr_data_r <= 1'b1;
                  entry_r <= entry_r + CW'(1);
                end else st_r <= lpht_pkg::ST_FULL;
                state_r <= S_WRITE;
              end
            end
          end else begin
            if (mark_q == lpht_pkg::MARK_EMPTY) state_r <= S_OUT;
            else if (match) begin
              idx_r <= s_r;
              if (op_r == lpht_pkg::OP_FIND) begin
                st_r <= lpht_pkg::ST_FOUND;
                co_r <= pay_q[31:0];
                vo_r <= pay_q[63:32];
                state_r <= S_OUT;
              end else begin
                st_r <= lpht_pkg::ST_REMOVED;
                wslot_r <= s_r;
                wr_tomb_r <= 1'b1;
                entry_r <= entry_r - CW'(1);
                state_r <= S_WRITE;
              end
            end else if (last) state_r <= S_OUT;
          end
        end
        S_WRITE: state_r <= S_OUT;
        S_OUT: begin
          out_v_r <= 1'b1;
          if (out_v_r && out_tready) begin
            out_v_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, 7'(used_r), 7'(entry_r), 6'(idx_r), vo_r, co_r, st_r};

  `include "linear_probe_hash_table_assert.svh"
  `LPHT_ASSERT_IMP(a_live_le_used, clk, rst_n, 1'b1, entry_r <= used_r)
  `LPHT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_v_r, state_r == S_OUT)
  `LPHT_ASSERT_NXT(a_out_done, clk, rst_n, out_v_r && out_tready, state_r == S_IDLE)
  `LPHT_ASSERT_IMP(a_hash_quiet, clk, rst_n, state_r == S_IDLE, !h_busy)
endmodule

>>> test/linear_probe_hash_table_test.sv
// Testbench for the linear-probing hash table: directed table, then random ops
`timescale 1ns / 1ps
module linear_probe_hash_table_test;
  localparam int SLOTS = 64;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [6:0]   cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;

  linear_probe_hash_table dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] chord;
    logic [31:0] voicing;
    logic [5:0]  slot;
    logic [6:0]  live;
    logic [6:0]  used;
  } reply_t;

  // table model
  logic [1:0]  mark_q [SLOTS];
  logic [63:0] key_q [SLOTS];
  logic [3:0]  klen_q [SLOTS];
  logic [31:0] chord_q [SLOTS];
  logic [31:0] voice_q [SLOTS];
  int unsigned live_cnt, used_cnt, limit_reg;

  reply_t expected_replies[$];
  int errors = 0;
  int cycles = 0;
  int replies_seen = 0;
  int sent = 0;
  int n_full = 0, n_found = 0, n_removed = 0, n_updated = 0;

  // keys from a small pool so inserts, finds and removes collide and hit
  logic [63:0] pool_key [16];
  logic [3:0]  pool_len [16];

  function automatic reply_t table_apply(logic [1:0] op, logic [63:0] kin,
                                         logic [3:0] lin, logic [31:0] cv,
                                         logic [31:0] vr);
    reply_t r;
    logic [63:0] k, h;
    int unsigned len, s, n, tomb;
    bit have_tomb, stop;
    r = '0;
    r.status = lpht_pkg::ST_NOTFOUND;
    len = (lin > 8) ? 8 : lin;
    k = (len < 8) ? (kin & ((64'd1 << (8 * len)) - 1)) : kin;
    h = lpht_pkg::DJB2_SEED;
    for (int i = 0; i < len; i++) h = h * 33 + ((k >> (8 * i)) & 64'hFF);
    s = 32'(h % SLOTS);
    have_tomb = 0;
    stop = 0;
    tomb = 0;
    if (op == lpht_pkg::OP_INSERT) begin
      r.status = lpht_pkg::ST_FULL;
      for (n = 0; n < SLOTS && !stop; n++) begin
        if (mark_q[s] == lpht_pkg::MARK_EMPTY) begin
          stop = 1;
          if (have_tomb || used_cnt < limit_reg) begin
            if (!have_tomb) begin
              tomb = s;
              used_cnt++;
            end
            have_tomb = 0;
            mark_q[tomb] = lpht_pkg::MARK_OCC; key_q[tomb] = k; klen_q[tomb] = 4'(len);
            chord_q[tomb] = cv; voice_q[tomb] = vr;
            live_cnt++;
            r.status = lpht_pkg::ST_INSERTED;
            r.slot = 6'(tomb);
          end
        end else if (mark_q[s] == lpht_pkg::MARK_TOMB) begin
          if (!have_tomb) begin
            have_tomb = 1;
            tomb = s;
          end
        end else if (klen_q[s] == len && key_q[s] == k) begin
          chord_q[s] = cv; voice_q[s] = vr;
          r.status = lpht_pkg::ST_UPDATED;
          r.slot = 6'(s);
          stop = 1;
        end
        s = (s + 1) % SLOTS;
      end
      // full walk over tombstones and live slots only
      if (!stop && have_tomb) begin
        mark_q[tomb] = lpht_pkg::MARK_OCC; key_q[tomb] = k; klen_q[tomb] = 4'(len);
        chord_q[tomb] = cv; voice_q[tomb] = vr;
        live_cnt++;
        r.status = lpht_pkg::ST_INSERTED;
        r.slot = 6'(tomb);
      end
    end else if (op == lpht_pkg::OP_FIND || op == lpht_pkg::OP_REMOVE) begin
      for (n = 0; n < SLOTS; n++) begin
        if (mark_q[s] == lpht_pkg::MARK_EMPTY) break;
        if (mark_q[s] == lpht_pkg::MARK_OCC && klen_q[s] == len && key_q[s] == k) begin
          r.slot = 6'(s);
          if (op == lpht_pkg::OP_FIND) begin
            r.status = lpht_pkg::ST_FOUND;
            r.chord = chord_q[s];
            r.voicing = voice_q[s];
          end else begin
            r.status = lpht_pkg::ST_REMOVED;
            mark_q[s] = lpht_pkg::MARK_TOMB;
            live_cnt--;
          end
          break;
        end
        s = (s + 1) % SLOTS;
      end
    end
    r.live = 7'(live_cnt);
    r.used = 7'(used_cnt);
    return r;
  endfunction

  function automatic void table_clear();
    for (int i = 0; i < SLOTS; i++) begin
      mark_q[i] = lpht_pkg::MARK_EMPTY;
      key_q[i] = '0; klen_q[i] = '0; chord_q[i] = '0; voice_q[i] = '0;
    end
    live_cnt = 0;
    used_cnt = 0;
  endfunction

  // result side: random stall per beat, check against the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[linear_probe_hash_table] ERROR");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      reply_t got, want;
      got = {out_tdata[2:0], out_tdata[34:3], out_tdata[66:35], out_tdata[72:67],
             out_tdata[79:73], out_tdata[86:80]};
      replies_seen <= replies_seen + 1;
      if (expected_replies.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.chord != want.chord) begin
          $error("chord_out: expected %h, got %h", want.chord, got.chord);
          errors++;
        end
        if (got.voicing != want.voicing) begin
          $error("voicing_out: expected %h, got %h", want.voicing, got.voicing);
          errors++;
        end
        if (got.slot != want.slot) begin
          $error("slot_index: expected %0d, got %0d", want.slot, got.slot);
          errors++;
        end
        if (got.live != want.live) begin
          $error("live_entries: expected %0d, got %0d", want.live, got.live);
          errors++;
        end
        if (got.used != want.used) begin
          $error("used_count: expected %0d, got %0d", want.used, got.used);
          errors++;
        end
      end
    end
  end

  // ready stall length drawn at random per beat
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_tready && out_tvalid) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= (stall_left == 0);
    end else if (!out_tready) begin
      if (stall_left > 0) stall_left = stall_left - 1;
      out_tready <= (stall_left == 0);
    end
  end

  // one beat: random gap, hold valid until accepted, queue the prediction
  task automatic send_op(logic [1:0] op, logic [63:0] k, logic [3:0] len,
                         logic [31:0] cv, logic [31:0] vr, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    repeat (gap) @(posedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, vr, cv, len, k, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_replies.push_back(table_apply(op, k, len, cv, vr));
    sent++;
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // pause until the block has drained, plus its own probe time
  task automatic drain();
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
  endtask

  typedef struct {
    logic [1:0]  op;
    logic [63:0] k;
    logic [3:0]  len;
    logic [31:0] cv;
    logic [31:0] vr;
    bit          typed;   // the expected reply is given below
    reply_t      want;
  } stim_row_t;

  stim_row_t directed[$];

  function automatic stim_row_t row(logic [1:0] op, logic [63:0] k, logic [3:0] len,
                                    logic [31:0] cv, logic [31:0] vr, bit typed,
                                    reply_t want);
    stim_row_t r;
    r.op = op; r.k = k; r.len = len; r.cv = cv; r.vr = vr;
    r.typed = typed; r.want = want;
    return r;
  endfunction

  initial begin
    reply_t pred;
    int idx, op_pick;
    logic [1:0] op;
    table_clear();
    limit_reg = 48;
    for (int i = 0; i < 16; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_len[i] = 4'($urandom_range(0, 8));
    end
    pool_key[0] = '1;
    pool_len[0] = 4'd15;

    // directed rows; the first few have obvious replies after reset
    directed.push_back(row(lpht_pkg::OP_FIND, 64'h0, 4'd0, 0, 0, 1,
                           '{lpht_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0}));
    directed.push_back(row(lpht_pkg::OP_REMOVE, '1, 4'd8, 0, 0, 1,
                           '{lpht_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0}));
    directed.push_back(row(OP_UNUSED, '1, 4'd15, '1, '1, 1,
                           '{lpht_pkg::ST_NOTFOUND, 0, 0, 0, 0, 0}));
    directed.push_back(row(lpht_pkg::OP_INSERT, 64'h0, 4'd0, '1, '1, 0, '0));
    directed.push_back(row(lpht_pkg::OP_INSERT, 64'h0, 4'd0, 32'h1, 32'h2, 0, '0));
    directed.push_back(row(lpht_pkg::OP_FIND, 64'hFFFF_FFFF_FFFF_FF00, 4'd0, 0, 0, 0,
                           '0));
    directed.push_back(row(lpht_pkg::OP_INSERT, '1, 4'd15, 32'hA5A5_5A5A, '0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_FIND, '1, 4'd8, 0, 0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_INSERT, 64'h00FF_FF41, 4'd1, 32'h11, 32'h22, 0,
                           '0));
    directed.push_back(row(lpht_pkg::OP_FIND, 64'h41, 4'd1, 0, 0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_FIND, 64'h41, 4'd2, 0, 0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_REMOVE, 64'h41, 4'd1, 0, 0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_FIND, 64'h41, 4'd1, 0, 0, 0, '0));
    directed.push_back(row(lpht_pkg::OP_INSERT, 64'h41, 4'd1, 32'h33, 32'h44, 0, '0));
    directed.push_back(row(lpht_pkg::OP_REMOVE, '1, 4'd9, 0, 0, 0, '0));
    directed.push_back(row(OP_UNUSED, 64'h0, 4'd0, 0, 0, 0, '0));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_op(directed[i].op, directed[i].k, directed[i].len,
              directed[i].cv, directed[i].vr, 1);
      if (directed[i].typed && expected_replies[$] != directed[i].want) begin
        $error("directed row %0d: typed reply %h, predicted %h", i,
               directed[i].want, expected_replies[$]);
        errors++;
      end
    end

    // zero limit: fresh-slot inserts refused, an insert to a live key still updates
    set_limit(0);
    send_op(lpht_pkg::OP_INSERT, 64'h1234, 4'd2, 1, 1, 0);
    send_op(lpht_pkg::OP_INSERT, 64'h41, 4'd1, 5, 6, 0);
    set_limit(127);

    // random phases with various limits; the pool keeps hit rates high
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: set_limit(64);
        2: set_limit(1);
        3: set_limit(20);
        4: set_limit(127);
        5: set_limit(48);
        default: ;
      endcase
      for (int i = 0; i < 100; i++) begin
        idx = $urandom_range(0, 15);
        op_pick = $urandom_range(0, 9);
        op = (op_pick < 5) ? lpht_pkg::OP_INSERT : (op_pick < 8) ? lpht_pkg::OP_FIND :
             (op_pick < 9) ? lpht_pkg::OP_REMOVE : OP_UNUSED;
        if ($urandom_range(0, 4) == 0)
          send_op(op, {$urandom, $urandom}, 4'($urandom_range(0, 15)),
                  $urandom, $urandom, 1);
        else
          send_op(op, pool_key[idx], pool_len[idx], $urandom, $urandom,
                  (i % 40) < 30);
        pred = expected_replies[$];
        if (pred.status == lpht_pkg::ST_FULL) n_full++;
        if (pred.status == lpht_pkg::ST_FOUND) n_found++;
        if (pred.status == lpht_pkg::ST_REMOVED) n_removed++;
        if (pred.status == lpht_pkg::ST_UPDATED) n_updated++;
        if (i == 50) drain();
      end
    end

    drain();
    $display("covered %0d ops: %0d found, %0d updated, %0d removed, %0d refused full",
             sent, n_found, n_updated, n_removed, n_full);
    $display("limits swept 0, 1, 20, 48, 64, 127; %0d result beats checked",
             replies_seen);
    if (errors == 0) begin
      $display("[linear_probe_hash_table] OK");
    end else begin
      $display("[linear_probe_hash_table] ERROR");
    end
    $finish;
  end
endmodule
